>>> hdl/lgr_pkg.sv
// Shared constants for the Life row-stream generation block.
`timescale 1ns / 1ps

package lgr_pkg;

    // Configuration register and APB port geometry
    localparam int GW_BITS        = 7;
    localparam int APB_AW         = 2;
    localparam int APB_DW         = 32;
    localparam logic [GW_BITS-1:0] GRID_WIDTH_RST = 7'd64;

    // Row geometry and output buffering
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int OUTQ_DEPTH     = 2;

endpackage

>>> hdl/lgr_cell.sv
// One lane: the B3/S23 rule for a single cell from its 3x3 neighborhood.
`timescale 1ns / 1ps

module lgr_cell
(
    input  logic [2:0] up,
    input  logic [2:0] mid,
    input  logic [2:0] dn,
    output logic       alive_next
);

    logic [3:0] ncount;

    always_comb
    begin
        ncount = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
               + 4'(mid[0]) + 4'(mid[2])
               + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
        alive_next = (ncount == 4'd3) || (mid[1] && (ncount == 4'd2));
    end

endmodule

>>> hdl/lgr_row.sv
// Row of lanes: masks the three input rows, runs one lane per column, merges the row.
`timescale 1ns / 1ps

module lgr_row
#(
    parameter int MAX_WIDTH = lgr_pkg::MAX_WIDTH_DEF
)
(
    input  logic [MAX_WIDTH-1:0]        up_row,
    input  logic [MAX_WIDTH-1:0]        mid_row,
    input  logic [MAX_WIDTH-1:0]        dn_row,
    input  logic [lgr_pkg::GW_BITS-1:0] width,
    output logic [MAX_WIDTH-1:0]        mask,
    output logic [MAX_WIDTH-1:0]        gen_row
);

    // One dead cell padded on each side
    logic [MAX_WIDTH+1:0] up_pad;
    logic [MAX_WIDTH+1:0] mid_pad;
    logic [MAX_WIDTH+1:0] dn_pad;
    logic [MAX_WIDTH-1:0] lane_out;

    assign up_pad  = {1'b0, up_row  & mask, 1'b0};
    assign mid_pad = {1'b0, mid_row & mask, 1'b0};
    assign dn_pad  = {1'b0, dn_row  & mask, 1'b0};

    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_lane
        localparam logic [lgr_pkg::GW_BITS-1:0] COL = lgr_pkg::GW_BITS'(k);

        assign mask[k] = (COL < width);

        lgr_cell u_cell
        (
            .up         (up_pad[k+2:k]),
            .mid        (mid_pad[k+2:k]),
            .dn         (dn_pad[k+2:k]),
            .alive_next (lane_out[k])
        );
    end

    assign gen_row = lane_out & mask;

endmodule

>>> hdl/lgr_outq.sv
// Small result queue between the lane array and the output channel.
`timescale 1ns / 1ps

module lgr_outq
#(
    parameter int DATA_W = lgr_pkg::MAX_WIDTH_DEF + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int DEPTH = lgr_pkg::OUTQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] q_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign room      = (count_reg != FULL_CNT);
    assign pop       = out_valid && out_ready;
    assign out_data  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/life_generation_row_stream_top.sv
// Top level: Life B3/S23 generation over a row stream, with APB width register.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  input     in         in_valid/in_ready    cells_row, last_row
//  output    out        out_valid/out_ready  next_row, run_last, frame_end
//  config    in/out     APB psel/penable     paddr, pwdata, prdata (grid_width)
//
// One row item per cycle while the result queue has room; a row carrying last_row
// after earlier rows adds the frame tail as a second row, during which input waits, as the
// lane array computes one output row per cycle. Results pass through the result queue.
// Reset clears the held rows and starts a new frame; grid_width resets to 64.
// A two-entry result queue lets input continue while a result waits downstream.
`timescale 1ns / 1ps

module life_generation_row_stream_top
#(
    parameter int MAX_WIDTH = lgr_pkg::MAX_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lgr_pkg::APB_AW-1:0] paddr,
    input  logic [lgr_pkg::APB_DW-1:0] pwdata,
    output logic [lgr_pkg::APB_DW-1:0] prdata,
    output logic                       pready,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MAX_WIDTH-1:0]       cells_row,
    input  logic                       last_row,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [MAX_WIDTH-1:0]       next_row,
    output logic                       run_last,
    output logic                       frame_end
);

    localparam int GW = lgr_pkg::GW_BITS;
    localparam logic [GW-1:0] MAX_W = GW'(MAX_WIDTH);

    typedef struct packed {
        logic run_last;
        logic frame_end;
    } res_flags_t;

    logic [GW-1:0]        grid_width_reg;
    logic [GW-1:0]        width_eff;
    logic [MAX_WIDTH-1:0] row_above_reg, row_above_next;
    logic [MAX_WIDTH-1:0] row_middle_reg, row_middle_next;
    logic                 have_row_reg, have_row_next;
    logic                 tail_reg, tail_next;

    logic [MAX_WIDTH-1:0] lane_up, lane_mid, lane_dn;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] gen_row;
    logic                 q_room;
    logic                 accept;
    logic                 push;
    res_flags_t           push_flags;
    res_flags_t           pop_flags;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = lgr_pkg::APB_DW'(grid_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= lgr_pkg::GRID_WIDTH_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            grid_width_reg <= pwdata[GW-1:0];
        end
    end

    assign width_eff = (grid_width_reg > MAX_W) ? MAX_W : grid_width_reg;

    // ---------------- row window ----------------
    assign in_ready = !tail_reg && q_room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        priority if (tail_reg)
        begin
            lane_up  = row_above_reg;
            lane_mid = row_middle_reg;
            lane_dn  = '0;
        end
        else if (!have_row_reg)
        begin
            lane_up  = '0;
            lane_mid = cells_row;
            lane_dn  = '0;
        end
        else
        begin
            lane_up  = row_above_reg;
            lane_mid = row_middle_reg;
            lane_dn  = cells_row;
        end
    end

    lgr_row #(.MAX_WIDTH(MAX_WIDTH)) u_row
    (
        .up_row  (lane_up),
        .mid_row (lane_mid),
        .dn_row  (lane_dn),
        .width   (width_eff),
        .mask    (mask),
        .gen_row (gen_row)
    );

    always_comb
    begin
        row_above_next  = row_above_reg;
        row_middle_next = row_middle_reg;
        have_row_next   = have_row_reg;
        tail_next       = tail_reg;
        push            = 1'b0;
        push_flags      = '{run_last: 1'b1, frame_end: 1'b1};

        priority if (tail_reg)
        begin
            // final row of the frame, then start over
            if (q_room)
            begin
                push            = 1'b1;
                tail_next       = 1'b0;
                row_above_next  = '0;
                row_middle_next = '0;
            end
        end
        else if (accept)
        begin
            if (!have_row_reg)
            begin
                // single-row frame emits at once; otherwise just hold the row
                push = last_row;
                if (!last_row)
                begin
                    row_above_next  = '0;
                    row_middle_next = cells_row & mask;
                    have_row_next   = 1'b1;
                end
            end
            else
            begin
                push            = 1'b1;
                push_flags      = '{run_last: !last_row, frame_end: 1'b0};
                row_above_next  = row_middle_reg & mask;
                row_middle_next = cells_row & mask;
                if (last_row)
                begin
                    tail_next     = 1'b1;
                    have_row_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg  <= '0;
            row_middle_reg <= '0;
            have_row_reg   <= 1'b0;
            tail_reg       <= 1'b0;
        end
        else
        begin
            row_above_reg  <= row_above_next;
            row_middle_reg <= row_middle_next;
            have_row_reg   <= have_row_next;
            tail_reg       <= tail_next;
        end
    end

    // ---------------- result queue ----------------
    lgr_outq #(.DATA_W(MAX_WIDTH + 2)) u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({gen_row, push_flags}),
        .room      (q_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  ({next_row, pop_flags})
    );

    assign run_last  = pop_flags.run_last;
    assign frame_end = pop_flags.frame_end;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the Life row-stream generation block.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int DIR_ROWS        = 19;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 160;

    localparam logic [lgr_pkg::APB_AW-1:0] GRID_WIDTH_ADDR = 2'd0;
    localparam logic [63:0]       ALL_ALIVE       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       EDGE_COLS       = 64'h8000_0000_0000_0001;

    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

    typedef struct packed {
        logic [63:0] next_row;
        logic        run_last;
        logic        frame_end;
    } gen_row_t;

    // typed: next_row of the item's results given by hand (first, then second)
    typedef struct packed {
        logic [63:0] cells;
        logic        last;
        logic        typed;
        logic [63:0] exp_a;
        logic [63:0] exp_b;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [lgr_pkg::APB_AW-1:0] paddr     = '0;
    logic [lgr_pkg::APB_DW-1:0] pwdata    = '0;
    logic [lgr_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [63:0]                cells_row = '0;
    logic                       last_row  = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [63:0]                next_row;
    logic                       run_last;
    logic                       frame_end;

    // predictor state
    logic [63:0]       gen_above;
    logic [63:0]       gen_middle;
    logic [1:0]        gen_rows_held;
    logic [6:0]        gen_width;
    gen_row_t          gen_q[$];

    int                err_count  = 0;
    int                cycle_cnt  = 0;
    int                burst_left = 0;
    logic              hold_req   = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{64'h0, 1'b1, 1'b1, 64'h0, 64'h0},                  // empty one-row frame
        '{ALL_ALIVE, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0},
        '{64'h0, 1'b0, 1'b0, 64'h0, 64'h0},                  // blinker turns vertical
        '{64'h0E, 1'b0, 1'b1, 64'h4, 64'h0},
        '{64'h0, 1'b1, 1'b1, 64'h4, 64'h4},
        '{ALL_ALIVE, 1'b0, 1'b0, 64'h0, 64'h0},              // full grid: corners live
        '{ALL_ALIVE, 1'b0, 1'b1, EDGE_COLS, 64'h0},
        '{ALL_ALIVE, 1'b1, 1'b1, 64'h0, EDGE_COLS},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0, 64'h0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 64'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0, 64'h0},
        '{64'h5555_5555_5555_5555, 1'b1, 1'b0, 64'h0, 64'h0},
        '{EDGE_COLS, 1'b0, 1'b0, 64'h0, 64'h0},
        '{EDGE_COLS, 1'b0, 1'b0, 64'h0, 64'h0},
        '{EDGE_COLS, 1'b1, 1'b0, 64'h0, 64'h0},
        '{64'hC000_0000_0000_0003, 1'b0, 1'b0, 64'h0, 64'h0}, // two-row frame
        '{64'hC000_0000_0000_0003, 1'b1, 1'b0, 64'h0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 64'h0, 64'h0},
        '{64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 64'h0, 64'h0}  // frame left open
    };

    life_generation_row_stream_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cells_row (cells_row),
        .last_row  (last_row),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .next_row  (next_row),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] width_mask(input logic [6:0] w);
        if (w >= 7'd64)
            return ALL_ALIVE;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] life_next(input logic [63:0] up, input logic [63:0] mid,
                                              input logic [63:0] down, input logic [63:0] mask);
        logic [63:0] res;
        int          cnt;
        int          j;
        up   = up & mask;
        mid  = mid & mask;
        down = down & mask;
        res  = '0;
        for (int k = 0; k < 64; k++)
        begin
            cnt = 0;
            for (int dk = -1; dk <= 1; dk++)
            begin
                j = k + dk;
                if (j >= 0 && j < 64)
                begin
                    cnt += up[j] + down[j];
                    if (dk != 0)
                        cnt += mid[j];
                end
            end
            res[k] = (cnt == 3) || (mid[k] && cnt == 2);
        end
        return res & mask;
    endfunction

    // Advances the three-row window by one input row; returns the number of rows produced.
    function automatic int advance_generation(input logic [63:0] cells, input logic last,
                                              output gen_row_t r0, output gen_row_t r1);
        logic [63:0] mask;
        logic [63:0] row;
        mask = width_mask(gen_width);
        row  = cells & mask;
        if (gen_rows_held == 2'd0)
        begin
            gen_above = '0;
            if (last)
            begin
                r0 = '{life_next(64'h0, row, 64'h0, mask), 1'b1, 1'b1};
                gen_middle = '0;
                return 1;
            end
            gen_middle    = row;
            gen_rows_held = 2'd1;
            return 0;
        end
        r0 = '{life_next(gen_above, gen_middle, row, mask), !last, 1'b0};
        gen_above     = gen_middle & mask;
        gen_middle    = row;
        gen_rows_held = 2'd2;
        if (!last)
            return 1;
        r1 = '{life_next(gen_above, gen_middle, 64'h0, mask), 1'b1, 1'b1};
        gen_above     = '0;
        gen_middle    = '0;
        gen_rows_held = 2'd0;
        return 2;
    endfunction

    function automatic logic [63:0] random_cells();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ALIVE;
            2: return r & {$urandom, $urandom} & {$urandom, $urandom};
            3: return r | {$urandom, $urandom};
            4: return 64'd1 << $urandom_range(0, 63);
            default: return r;
        endcase
    endfunction

    // Write grid_width, then read it back.
    task automatic set_grid_width(input logic [6:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRID_WIDTH_ADDR;
        pwdata  <= lgr_pkg::APB_DW'(w);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[lgr_pkg::GW_BITS-1:0] !== w)
        begin
            $error("grid_width: expected %0d, got %0d", w, prdata[lgr_pkg::GW_BITS-1:0]);
            err_count++;
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        gen_width  = w;
    endtask

    task automatic send_row(input logic [63:0] cells, input logic last, input logic typed,
                            input logic [63:0] exp_a, input logic [63:0] exp_b);
        gen_row_t r0;
        gen_row_t r1;
        int       n;
        int       gap;
        in_valid  <= 1'b1;
        cells_row <= cells;
        last_row  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = advance_generation(cells, last, r0, r1);
        if (typed)
        begin
            r0.next_row = exp_a;
            r1.next_row = exp_b;
        end
        if (n >= 1)
            gen_q.push_back(r0);
        if (n == 2)
            gen_q.push_back(r1);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Result checker and output-side stall pattern.
    always @(posedge clk)
    begin : rx_blk
        gen_row_t        exp_r;
        static rx_mode_e rx_mode  = RX_ALWAYS;
        static int       rx_left  = 0;
        static int       hold_cnt = 0;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (gen_q.size() == 0)
            begin
                $error("result with nothing expected: next_row %h", next_row);
                err_count++;
            end
            else
            begin
                exp_r = gen_q.pop_front();
                if (next_row !== exp_r.next_row)
                begin
                    $error("next_row: expected %h, got %h", exp_r.next_row, next_row);
                    err_count++;
                end
                if (run_last !== exp_r.run_last)
                begin
                    $error("run_last: expected %b, got %b", exp_r.run_last, run_last);
                    err_count++;
                end
                if (frame_end !== exp_r.frame_end)
                begin
                    $error("frame_end: expected %b, got %b", exp_r.frame_end, frame_end);
                    err_count++;
                end
            end
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 60);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] phase_width [NUM_PHASES];
        int         last_odds;
        phase_width = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3, 7'd33, 7'd63, 7'd64, 7'd17, 7'd40};
        phase_width[NUM_PHASES-1] = 7'($urandom_range(1, 64));
        gen_above     = '0;
        gen_middle    = '0;
        gen_rows_held = 2'd0;
        gen_width     = lgr_pkg::GRID_WIDTH_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_grid_width(7'd64);

        foreach (dir_tab[i])
            send_row(dir_tab[i].cells, dir_tab[i].last, dir_tab[i].typed,
                     dir_tab[i].exp_a, dir_tab[i].exp_b);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // width changes only with no result outstanding; frames may stay open across it
            in_valid <= 1'b0;
            while (gen_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            set_grid_width(phase_width[p]);
            last_odds = $urandom_range(0, 12);
            if (p == 2 || p == 6)
            begin
                hold_req   = 1'b1;
                burst_left = 80;
            end
            repeat (ITEMS_PER_PHASE)
                send_row(random_cells(), $urandom_range(0, last_odds) == 0, 1'b0, '0, '0);
        end

        in_valid <= 1'b0;
        while (gen_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lgr_pkg.sv
hdl/lgr_cell.sv
hdl/lgr_row.sv
hdl/lgr_outq.sv
hdl/life_generation_row_stream_top.sv
tb/tb_top.sv
